// ----- sv/insulation_resistance_monitor_core_defines.svh -----
// ----------------------------------------------------------------------------
// insulation resistance monitor assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef INSULATION_RESISTANCE_MONITOR_CORE_DEFINES_SVH
`define INSULATION_RESISTANCE_MONITOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IRM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IRM_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRM_ASSERT(lbl, clk, rst_n, prop, msg)
`define IRM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/irm_pkg.sv -----
// ----------------------------------------------------------------------------
// irm_pkg
// types and constants shared by the insulation resistance monitor
// ----------------------------------------------------------------------------
package irm_pkg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] bus_voltage_q4;
        logic signed [15:0] leak_voltage;
        logic               link_ok;
        logic               relay_on;
        logic [3:0]         notch;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic       ground_plus;
        logic       ground_minus;
        logic       low_plus;
        logic       low_minus;
        logic [9:0] r_plus;
        logic [9:0] r_minus;
        logic       r_plus_written;
        logic       r_minus_written;
    } out_beat_t;

    // job handed from front to back
    typedef struct packed {
        logic        calc;
        out_beat_t   direct;
        logic [16:0] u16;
        logic [15:0] up;
        logic [15:0] um;
    } job_t;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_LINK   = 2'd1;
    localparam logic [1:0] ST_GROUND = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] REG_SETTLE = 2'd0;
    localparam logic [1:0] REG_MINBUS = 2'd1;
    localparam logic [1:0] REG_LOWLIM = 2'd2;
    localparam logic [1:0] REG_SCALE  = 2'd3;

    localparam logic [9:0] R_TOP   = 10'd997;
    localparam logic [9:0] R_CLAMP = 10'd998;

    function automatic logic [16:0] abs16(input logic [15:0] v);
        logic [16:0] r;
        r = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        return r;
    endfunction

endpackage

// ----- sv/irm_front.sv -----
// ----------------------------------------------------------------------------
// irm_front
// gating, relay sync, settle timers and ground check per sample
// ----------------------------------------------------------------------------
module irm_front import irm_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job_data,
    input  logic [15:0] settle_ms,
    input  logic [11:0] min_bus
);

    logic [1:0]           relay_seen_reg, relay_seen_next;
    logic                 synced_reg, synced_next;
    logic                 pt_run_reg, pt_run_next, mt_run_reg, mt_run_next;
    logic [TIME_BITS-1:0] pt_start_reg, pt_start_next, mt_start_reg, mt_start_next;
    logic [15:0]          up_reg, up_next, um_reg, um_next;
    logic                 jv_reg;
    job_t                 job_reg, job_next;

    logic [TIME_BITS-1:0] now_t, elapsed;
    logic [16:0]          u16, leak;
    logic [20:0]          thr_p, thr_m;
    logic                 go, fire, gp, gm, done;

    assign in_ready  = !jv_reg || job_ready;
    assign job_valid = jv_reg;
    assign job_data  = job_reg;
    assign fire      = in_valid && in_ready;

    assign now_t = TIME_BITS'(in_data.now_ms);

    assign u16  = abs16(in_data.bus_voltage_q4);
    assign leak = abs16(in_data.leak_voltage);

    always_comb
    begin
        relay_seen_next = relay_seen_reg;
        synced_next     = synced_reg;
        pt_run_next     = pt_run_reg;
        mt_run_next     = mt_run_reg;
        pt_start_next   = pt_start_reg;
        mt_start_next   = mt_start_reg;
        up_next         = up_reg;
        um_next         = um_reg;
        job_next        = '0;
        job_next.u16    = u16;
        done            = 1'b0;
        go              = 1'b0;
        elapsed         = '0;
        gp              = 1'b0;
        gm              = 1'b0;
        thr_p           = '0;
        thr_m           = '0;
        if (u16 < {5'd0, min_bus} || !in_data.link_ok ||
            !(in_data.notch == 4'd1 || in_data.notch == 4'd2))
        begin
            relay_seen_next = 2'd2;
            synced_next     = 1'b0;
            pt_run_next     = 1'b0;
            mt_run_next     = 1'b0;
            pt_start_next   = '0;
            mt_start_next   = '0;
            up_next         = '0;
            um_next         = '0;
            if (!in_data.link_ok)
                job_next.direct.status = ST_LINK;
        end
        else
        begin
            go = 1'b1;
            if (!synced_reg)
            begin
                if (relay_seen_reg == 2'd2)
                begin
                    relay_seen_next = {1'b0, in_data.relay_on};
                    go = 1'b0;
                end
                else if (relay_seen_reg[0] == in_data.relay_on)
                    go = 1'b0;
                else
                    synced_next = 1'b1;
            end
            if (go)
            begin
                if (in_data.relay_on)
                begin
                    mt_run_next   = 1'b0;
                    mt_start_next = '0;
                    elapsed = now_t - pt_start_reg;
                    if (!pt_run_reg)
                    begin
                        pt_run_next   = 1'b1;
                        pt_start_next = now_t;
                    end
                    else if (elapsed >= TIME_BITS'(settle_ms))
                    begin
                        pt_run_next   = 1'b0;
                        pt_start_next = '0;
                        up_next       = leak[15:0];
                        done          = 1'b1;
                    end
                end
                else
                begin
                    pt_run_next   = 1'b0;
                    pt_start_next = '0;
                    elapsed = now_t - mt_start_reg;
                    if (!mt_run_reg)
                    begin
                        mt_run_next   = 1'b1;
                        mt_start_next = now_t;
                    end
                    else if (elapsed >= TIME_BITS'(settle_ms))
                    begin
                        mt_run_next   = 1'b0;
                        mt_start_next = '0;
                        um_next       = leak[15:0];
                        done          = 1'b1;
                    end
                end
            end
            // leak 0x8000 gives 0 in 16 bits only if abs is 0, so [15:0] is safe
            if (done && up_next != 16'd0 && um_next != 16'd0)
            begin
                thr_m = {1'b0, um_next, 4'd0} + 21'd16;
                thr_p = {1'b0, up_next, 4'd0} + 21'd16;
                gp = thr_m > {4'd0, u16};
                gm = thr_p > {4'd0, u16};
                job_next.up = up_next;
                job_next.um = um_next;
                if (gp || gm)
                begin
                    job_next.direct.status          = ST_GROUND;
                    job_next.direct.ground_plus     = gp;
                    job_next.direct.ground_minus    = gm;
                    job_next.direct.r_plus          = gp ? 10'd1 : 10'd0;
                    job_next.direct.r_plus_written  = gp;
                    job_next.direct.r_minus         = gm ? 10'd1 : 10'd0;
                    job_next.direct.r_minus_written = gm;
                end
                else
                    job_next.calc = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_seen_reg <= 2'd2;
            synced_reg     <= 1'b0;
            pt_run_reg     <= 1'b0;
            mt_run_reg     <= 1'b0;
            pt_start_reg   <= '0;
            mt_start_reg   <= '0;
            up_reg         <= '0;
            um_reg         <= '0;
            jv_reg         <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                relay_seen_reg <= relay_seen_next;
                synced_reg     <= synced_next;
                pt_run_reg     <= pt_run_next;
                mt_run_reg     <= mt_run_next;
                pt_start_reg   <= pt_start_next;
                mt_start_reg   <= mt_start_next;
                up_reg         <= up_next;
                um_reg         <= um_next;
                jv_reg         <= 1'b1;
            end
            else if (job_ready)
                jv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            job_reg <= job_next;
    end

endmodule

// ----- sv/irm_back.sv -----
// ----------------------------------------------------------------------------
// irm_back
// bit-serial division for both resistances, clamp and low flags
// ----------------------------------------------------------------------------
module irm_back import irm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    input  logic [9:0]  low_limit,
    input  logic [9:0]  scale
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg;
    logic        side_reg;
    logic [4:0]  cnt_reg;
    job_t        job_reg;
    logic        pos_reg;
    logic [26:0] n_reg;
    logic        over_reg;
    logic [26:0] rem_reg;
    logic [26:0] q_reg;
    logic [9:0]  rp_reg;
    out_beat_t   out_reg;

    logic [20:0] d, sum16;
    logic [21:0] res;
    logic [27:0] trial;
    logic [26:0] n_full, top_full;
    logic [9:0]  r;

    assign job_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data  = out_reg;

    assign sum16    = {1'b0, job_reg.up, 4'd0} + {1'b0, job_reg.um, 4'd0};
    assign res      = {5'd0, job_reg.u16} - {1'b0, sum16};
    assign d        = side_reg ? {1'b0, job_reg.up, 4'd0} : {1'b0, job_reg.um, 4'd0};
    assign trial    = {rem_reg, n_reg[26]} - {7'd0, d};
    assign n_full   = {17'd0, scale} * {10'd0, res[16:0]};
    assign top_full = {17'd0, R_TOP} * {6'd0, d};

    always_comb
    begin
        if (!pos_reg)
            r = 10'd1;
        else if (over_reg)
            r = R_CLAMP;
        else if (q_reg < 27'd2)
            r = 10'd1;
        else
            r = q_reg[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            side_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        side_reg  <= 1'b0;
                        state_reg <= job_data.calc ? S_MUL : S_OUT;
                    end
                S_MUL:
                begin
                    cnt_reg   <= 5'd27;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    side_reg  <= 1'b1;
                    state_reg <= side_reg ? S_OUT : S_MUL;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (job_valid)
                begin
                    job_reg <= job_data;
                    out_reg <= job_data.direct;
                end
            S_MUL:
            begin
                pos_reg  <= !res[21] && res != 22'd0;
                n_reg    <= n_full;
                over_reg <= n_full > top_full;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            S_DIV:
            begin
                n_reg <= {n_reg[25:0], 1'b0};
                if (!trial[27])
                begin
                    rem_reg <= trial[26:0];
                    q_reg   <= {q_reg[25:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[25:0], n_reg[26]};
                    q_reg   <= {q_reg[25:0], 1'b0};
                end
            end
            S_FIN:
            begin
                if (side_reg)
                begin
                    out_reg.status          <= ST_FULL;
                    out_reg.r_minus         <= r;
                    out_reg.low_minus       <= r < low_limit;
                    out_reg.r_plus          <= rp_reg;
                    out_reg.low_plus        <= rp_reg < low_limit;
                    out_reg.r_plus_written  <= 1'b1;
                    out_reg.r_minus_written <= 1'b1;
                end
                else
                    rp_reg <= r;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/insulation_resistance_monitor_core.sv -----
// ----------------------------------------------------------------------------
// insulation_resistance_monitor_core
// insulation resistance monitor with ground fault and low resistance flags
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready/in_data) takes one sample beat, out channel
// (out_valid/out_ready/out_data) returns exactly one result beat per sample.
// cfg_we/cfg_index/cfg_data write the four settings; the user must write
// them only while idle, the block does not enforce it. front stage registers
// gating, relay sync and settle timers and hands a job to a one-entry queue;
// the back stage runs a 27 step restoring divider once per side for full
// measurements, stepping S_MUL, S_DIV and S_FIN per side before S_OUT; one
// beat is taken while the back stage works, so the front stalls only while
// the queue is full.
// reset clears sync, timers, latched leak voltages and loads default settings.
// a stalled receiver holds the back stage, which in turn fills the queue and
// then drops in_ready.
// ----------------------------------------------------------------------------
`include "insulation_resistance_monitor_core_defines.svh"

module insulation_resistance_monitor_core import irm_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] settle_reg;
    logic [11:0] minbus_reg;
    logic [9:0]  lowlim_reg;
    logic [9:0]  scale_reg;
    logic        job_valid, job_ready;
    job_t        job_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 16'd9000;
            minbus_reg <= 12'd640;
            lowlim_reg <= 10'd250;
            scale_reg  <= 10'd666;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETTLE: settle_reg <= cfg_data;
                REG_MINBUS: minbus_reg <= cfg_data[11:0];
                REG_LOWLIM: lowlim_reg <= cfg_data[9:0];
                REG_SCALE:  scale_reg  <= cfg_data[9:0];
                default:    settle_reg <= settle_reg;
            endcase
        end
    end

    irm_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .settle_ms (settle_reg),
        .min_bus   (minbus_reg)
    );

    irm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .low_limit (lowlim_reg),
        .scale     (scale_reg)
    );

    `IRM_ASSERT(a_full_writes, clk, rst_n,
        out_valid && out_data.status == ST_FULL |->
        out_data.r_plus_written && out_data.r_minus_written, "full result lacks writes")
    `IRM_ASSERT(a_idle_zero, clk, rst_n,
        out_valid && out_data.status == ST_NONE |-> !out_data.r_plus_written &&
        !out_data.r_minus_written, "no-update result carries data")
    `IRM_ASSERT(a_clamp, clk, rst_n,
        out_valid |-> out_data.r_plus <= 10'd998 && out_data.r_minus <= 10'd998,
        "resistance out of range")

endmodule
